@@ rtl/qrs_pkg.sv @@
// Shared types and constants for the quadratic root solver pipeline.
// No dependencies; imported by every module of the block.
package qrs_pkg;

  localparam int CoefW    = 16;
  localparam int DiscW    = 34;
  localparam int RadInW   = DiscW - 1;          // non-negative discriminant
  localparam int SqrtBits = 25;                 // floor sqrt of (disc << 16)
  localparam int RadBits  = 2 * SqrtBits;
  localparam int SqrtRemW = SqrtBits + 2;
  localparam int DivBits  = 40;                 // numerator magnitude width
  localparam int DenW     = CoefW;
  localparam int NumDivs  = 4;
  localparam int ResW     = 32;

  localparam int IdxPlus  = 0;
  localparam int IdxMinus = 1;
  localparam int IdxVx    = 2;
  localparam int IdxVy    = 3;

  typedef enum logic [1:0] {
    ST_ZERO_A    = 2'd0,
    ST_TWO_ROOTS = 2'd1,
    ST_ONE_ROOT  = 2'd2,
    ST_NO_ROOT   = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [DiscW-1:0] disc;
    status_e                 status;
  } sqrt_side_t;

  typedef struct packed {
    logic signed [DiscW-1:0] disc;
    status_e                 status;
    logic [NumDivs-1:0]      neg;
  } div_side_t;

endpackage

@@ rtl/qrs_sqrt_pipe.sv @@
// Pipelined floor square root, one result bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt_pipe import qrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [RadInW-1:0]   rad_i,
  input  sqrt_side_t          side_i,
  output logic                valid_o,
  output logic [SqrtBits-1:0] root_o,
  output sqrt_side_t          side_o
);

  logic [SqrtBits-1:0]                valid_q;
  logic [SqrtBits-1:0][RadBits-1:0]  rad_q;
  logic [SqrtBits-1:0][SqrtBits-1:0] root_q;
  logic [SqrtBits-1:0][SqrtRemW-1:0] rem_q;
  sqrt_side_t                         side_q [SqrtBits];

  for (genvar k = 0; k < SqrtBits; k++) begin : g_stage
    logic                  vld_c;
    logic [RadBits-1:0]    rad_c;
    logic [SqrtBits-1:0]   root_c;
    logic [SqrtRemW-1:0]   rem_c;
    sqrt_side_t            side_c;
    logic [SqrtRemW+1:0]   rem_sh;
    logic [SqrtRemW+1:0]   trial;
    logic                  ge;

    if (k == 0) begin : g_first
      assign vld_c  = valid_i;
      assign rad_c  = {1'b0, rad_i, 16'd0};
      assign root_c = '0;
      assign rem_c  = '0;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = valid_q[k-1];
      assign rad_c  = rad_q[k-1];
      assign root_c = root_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign side_c = side_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_c, rad_c[RadBits-1 -: 2]};
      trial  = {2'b00, root_c, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_c[RadBits-3:0], 2'b00};
      root_q[k] <= {root_c[SqrtBits-2:0], ge};
      rem_q[k]  <= ge ? SqrtRemW'(rem_sh - trial) : SqrtRemW'(rem_sh);
      side_q[k] <= side_c;
    end
  end

  assign valid_o = valid_q[SqrtBits-1];
  assign root_o  = root_q[SqrtBits-1];
  assign side_o  = side_q[SqrtBits-1];

endmodule

@@ rtl/qrs_div_pipe.sv @@
// Pipelined unsigned restoring divider: four numerators over one divisor,
// one quotient bit per stage. Depends on qrs_pkg.
module qrs_div_pipe import qrs_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [NumDivs-1:0][DivBits-1:0]   num_i,
  input  logic [DenW-1:0]                   den_i,
  input  div_side_t                         side_i,
  output logic                              valid_o,
  output logic [NumDivs-1:0][DivBits-1:0]   quo_o,
  output div_side_t                         side_o
);

  logic [DivBits-1:0]                              valid_q;
  logic [DivBits-1:0][NumDivs-1:0][DivBits-1:0]    work_q;  // numerator out, quotient in
  logic [DivBits-1:0][NumDivs-1:0][DenW-1:0]       rem_q;
  logic [DivBits-1:0][DenW-1:0]                    den_q;
  div_side_t                                       side_q [DivBits];

  for (genvar k = 0; k < DivBits; k++) begin : g_stage
    logic                              vld_c;
    logic [NumDivs-1:0][DivBits-1:0]   work_c;
    logic [NumDivs-1:0][DenW-1:0]      rem_c;
    logic [DenW-1:0]                   den_c;
    div_side_t                         side_c;
    logic [NumDivs-1:0][DivBits-1:0]   work_n;
    logic [NumDivs-1:0][DenW-1:0]      rem_n;

    if (k == 0) begin : g_first
      assign vld_c  = valid_i;
      assign work_c = num_i;
      assign rem_c  = '0;
      assign den_c  = den_i;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = valid_q[k-1];
      assign work_c = work_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign den_c  = den_q[k-1];
      assign side_c = side_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < NumDivs; i++) begin
        logic [DenW:0] sh;
        logic          ge;
        sh = {rem_c[i], work_c[i][DivBits-1]};
        ge = (sh >= {1'b0, den_c});
        rem_n[i]  = ge ? DenW'(sh - {1'b0, den_c}) : DenW'(sh);
        work_n[i] = {work_c[i][DivBits-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      work_q[k] <= work_n;
      rem_q[k]  <= rem_n;
      den_q[k]  <= den_c;
      side_q[k] <= side_c;
    end
  end

  assign valid_o = valid_q[DivBits-1];
  assign quo_o   = work_q[DivBits-1];
  assign side_o  = side_q[DivBits-1];

endmodule

@@ rtl/quadratic_root_solver_unit.sv @@
// Quadratic root solver: discriminant, status, real roots and vertex x in Q16.16, vertex y in Q24.8.
// Accepts one request per cycle; busy stays low.
// Stages: products, discriminant, 25-stage square root, numerators,
// 40-stage divider, output register. The receiver cannot stall.
// Reset (async, active low) clears all valid bits and the done strobe.
module quadratic_root_solver_unit import qrs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CoefW-1:0] coef_a_i,
  input  logic signed [CoefW-1:0] coef_b_i,
  input  logic signed [CoefW-1:0] coef_c_i,
  output logic                    done_o,
  output logic [1:0]              root_status_o,
  output logic signed [DiscW-1:0] discriminant_o,
  output logic signed [ResW-1:0]  root_plus_o,
  output logic signed [ResW-1:0]  root_minus_o,
  output logic signed [ResW-1:0]  vertex_x_o,
  output logic signed [ResW-1:0]  vertex_y_o,
  output logic                    saturated_o
);

  localparam int NumW = DivBits + 1;

  // clamp signed magnitude quotient; returns {sat, value}
  function automatic logic [ResW:0] sat_fix(input logic [DivBits-1:0] q, input logic neg);
    logic [ResW:0] r;
    if (neg) begin
      if ((|q[DivBits-1:ResW]) || (q[ResW-1] && (|q[ResW-2:0]))) begin
        r = {1'b1, 1'b1, {(ResW-1){1'b0}}};
      end else begin
        r = {1'b0, ResW'(-q[ResW-1:0])};
      end
    end else begin
      if (|q[DivBits-1:ResW-1]) begin
        r = {1'b1, 1'b0, {(ResW-1){1'b1}}};
      end else begin
        r = {1'b0, q[ResW-1:0]};
      end
    end
    return r;
  endfunction

  assign busy = 1'b0;

  // stage 1: products
  logic                    v1_q;
  logic signed [CoefW-1:0] a1_q, b1_q;
  logic signed [31:0]      bb1_q, ac1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q  <= coef_a_i;
    b1_q  <= coef_b_i;
    bb1_q <= coef_b_i * coef_b_i;
    ac1_q <= coef_a_i * coef_c_i;
  end

  // stage 2: discriminant and status
  logic       v2_q;
  sqrt_side_t side2_d, side2_q;

  always_comb begin
    side2_d.a    = a1_q;
    side2_d.b    = b1_q;
    side2_d.disc = DiscW'(bb1_q) - {ac1_q, 2'b00};
    if (a1_q == '0) begin
      side2_d.status = ST_ZERO_A;
    end else if (side2_d.disc[DiscW-1]) begin
      side2_d.status = ST_NO_ROOT;
    end else if (side2_d.disc == '0) begin
      side2_d.status = ST_ONE_ROOT;
    end else begin
      side2_d.status = ST_TWO_ROOTS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q <= side2_d;
  end

  // square root
  logic                sq_v;
  logic [SqrtBits-1:0] sq_root;
  sqrt_side_t          sq_side;

  qrs_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .rad_i   (side2_q.disc[DiscW-1] ? RadInW'(0) : side2_q.disc[RadInW-1:0]),
    .side_i  (side2_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // stage 3: numerators as sign and magnitude
  logic                            v3_q;
  logic [NumDivs-1:0][DivBits-1:0] num3_d, num3_q;
  logic [DenW-1:0]                 den3_d, den3_q;
  div_side_t                       side3_d, side3_q;

  always_comb begin
    logic signed [NumW-1:0] sb, nb, sr, sd;
    logic signed [NumW-1:0] nums [NumDivs];
    sb = NumW'(sq_side.b);
    sr = NumW'({1'b0, sq_root});
    sd = NumW'(sq_side.disc);
    nb = -(sb <<< 8);
    nums[IdxPlus]  = (nb + sr) <<< 7;
    nums[IdxMinus] = (nb - sr) <<< 7;
    nums[IdxVx]    = -(sb <<< 15);
    nums[IdxVy]    = -(sd <<< 6);
    for (int i = 0; i < NumDivs; i++) begin
      num3_d[i]      = nums[i][NumW-1] ? DivBits'(-nums[i]) : DivBits'(nums[i]);
      side3_d.neg[i] = nums[i][NumW-1] ^ sq_side.a[CoefW-1];
    end
    if (sq_side.a == '0) begin
      den3_d = DenW'(1);
    end else begin
      den3_d = sq_side.a[CoefW-1] ? DenW'(-sq_side.a) : DenW'(sq_side.a);
    end
    side3_d.disc   = sq_side.disc;
    side3_d.status = sq_side.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    num3_q  <= num3_d;
    den3_q  <= den3_d;
    side3_q <= side3_d;
  end

  // division
  logic                            dv_v;
  logic [NumDivs-1:0][DivBits-1:0] dv_quo;
  div_side_t                       dv_side;

  qrs_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .num_i   (num3_q),
    .den_i   (den3_q),
    .side_i  (side3_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // output stage: clamp and mask
  logic                    done_q;
  logic [1:0]              status_d, status_q;
  logic signed [DiscW-1:0] disc_d, disc_q;
  logic signed [ResW-1:0]  rp_d, rm_d, vx_d, vy_d, rp_q, rm_q, vx_q, vy_q;
  logic                    sat_d, sat_q;

  always_comb begin
    logic [ResW:0] fp, fm, fx, fy;
    logic          has_roots;
    fp = sat_fix(dv_quo[IdxPlus],  dv_side.neg[IdxPlus]);
    fm = sat_fix(dv_quo[IdxMinus], dv_side.neg[IdxMinus]);
    fx = sat_fix(dv_quo[IdxVx],    dv_side.neg[IdxVx]);
    fy = sat_fix(dv_quo[IdxVy],    dv_side.neg[IdxVy]);
    has_roots = (dv_side.status == ST_TWO_ROOTS) || (dv_side.status == ST_ONE_ROOT);
    status_d  = dv_side.status;
    if (dv_side.status == ST_ZERO_A) begin
      disc_d = '0;
      rp_d   = '0;
      rm_d   = '0;
      vx_d   = '0;
      vy_d   = '0;
      sat_d  = 1'b0;
    end else begin
      disc_d = dv_side.disc;
      rp_d   = has_roots ? fp[ResW-1:0] : '0;
      rm_d   = has_roots ? fm[ResW-1:0] : '0;
      vx_d   = fx[ResW-1:0];
      vy_d   = fy[ResW-1:0];
      sat_d  = (has_roots && (fp[ResW] || fm[ResW])) || fx[ResW] || fy[ResW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    disc_q   <= disc_d;
    rp_q     <= rp_d;
    rm_q     <= rm_d;
    vx_q     <= vx_d;
    vy_q     <= vy_d;
    sat_q    <= sat_d;
  end

  assign done_o         = done_q;
  assign root_status_o  = status_q;
  assign discriminant_o = disc_q;
  assign root_plus_o    = rp_q;
  assign root_minus_o   = rm_q;
  assign vertex_x_o     = vx_q;
  assign vertex_y_o     = vy_q;
  assign saturated_o    = sat_q;

  a_zero_a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (root_status_o == ST_ZERO_A) |->
      (discriminant_o == '0) && (vertex_x_o == '0) && (vertex_y_o == '0) && !saturated_o)
    else $error("zero a result not cleared");

  a_no_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (root_status_o == ST_NO_ROOT) |->
      (root_plus_o == '0) && (root_minus_o == '0) && discriminant_o[DiscW-1])
    else $error("no-root result inconsistent");

  a_one_root_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (root_status_o == ST_ONE_ROOT) |->
      (root_plus_o == root_minus_o) && (discriminant_o == '0))
    else $error("double root mismatch");

  a_two_roots_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (root_status_o == ST_TWO_ROOTS) |->
      !discriminant_o[DiscW-1] && (discriminant_o != '0))
    else $error("two roots with non-positive discriminant");

  a_done_follows_v3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ##(DivBits + 1) done_o)
    else $error("request lost in divider");

endmodule
